/* hdl/lssp_pkg.sv */
// Shared types and constants for the link-state shortest-path engine.
package lssp_pkg;

    localparam int NODES = 16;
    localparam int NW = $clog2(NODES);
    localparam int LW = 2 * NW;
    localparam logic [31:0] COST_UNUSABLE = 32'hFFFF_FFFF;
    localparam logic [31:0] COST_MAX = 32'hFFFF_FFFE;
    localparam logic [47:0] BW_SCALE = 48'd2560000;
    localparam logic [16:0] LOSS_FULL = 17'd65536;

    typedef struct packed {
        logic        func;
        logic [3:0]  src_node;
        logic [3:0]  dst_node;
        logic        both_directions;
        logic [19:0] link_bandwidth;
        logic [23:0] link_latency;
        logic [16:0] link_loss;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  path_node;
        logic [31:0] path_cost;
        logic        path_found;
        logic        last;
    } res_t;

endpackage

/* hdl/lssp_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
module lssp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/link_state_shortest_path.sv */
// Top level: link-state shortest-path engine with a shared divider and sequencer.
//
//  channel | signals            | handshake
//  --------+--------------------+-----------------------------------------
//  command | start, busy, cmd   | taken on a clock edge with start && !busy
//  result  | res_valid, res     | one cycle per item, receiver cannot stall
//
// An add item keeps busy high while the shared restoring divider runs twice, first
// for 2560000/bandwidth, then for the loss scaling, and then does two link writes.
// A find item repeats, for each settled node, one minimum scan over NODES entries
// (one per cycle) and one relax pass over NODES links, in which each link read is
// requested in S_RREQ and its cost RAM data used in S_RELAX; then a path walk and
// one result per cycle.
// Reset clears node and link valid bits at once; no clearing pass is needed.
module link_state_shortest_path (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  lssp_pkg::cmd_t   cmd,
    output logic             res_valid,
    output lssp_pkg::res_t   res
);
    import lssp_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_DIV1  = 12'b000000000010,
        S_DIV2  = 12'b000000000100,
        S_WR1   = 12'b000000001000,
        S_WR2   = 12'b000000010000,
        S_SCAN  = 12'b000000100000,
        S_RREQ  = 12'b000001000000,
        S_RELAX = 12'b000010000000,
        S_WALK  = 12'b000100000000,
        S_EMIT  = 12'b001000000000,
        S_FAIL  = 12'b010000000000,
        S_SAME  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg;

    logic [NODES-1:0]       node_present_reg;
    logic [NODES*NODES-1:0] link_present_reg;
    logic [NODES-1:0]       visited_reg;
    logic [31:0]            dist_reg [NODES];
    logic [NW-1:0]          pred_reg [NODES];
    logic [NW-1:0]          chain_reg [NODES];

    // shared restoring divider: quotient/remainder over 48 bits
    logic [47:0] num_reg, quo_reg, den_reg;
    logic [48:0] rem_reg;
    logic [5:0]  step_reg;
    logic [47:0] cost_wide_reg;
    logic [31:0] cost_reg;

    logic [NW-1:0] idx_reg, u_reg, cur_reg;
    logic [NW:0]   n_reg, out_reg;
    logic          found_u_reg;
    logic [31:0]   bd_reg;

    // link cost memory
    logic          ram_we;
    logic [LW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;

    lssp_ram #(.WIDTH(32), .DEPTH(NODES*NODES)) u_cost (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    logic [48:0] rem_shift;
    logic        div_bit;
    logic [47:0] div_quo;
    logic [47:0] base_sum;
    logic [32:0] relax_sum;
    logic [31:0] relax_sat;
    logic [LW-1:0] link_ix;
    logic        scan_hit;
    logic        walk_end;

    assign rem_shift = {rem_reg[47:0], num_reg[47]};
    assign div_bit   = (rem_shift >= {1'b0, den_reg});
    assign div_quo   = {quo_reg[46:0], div_bit};
    assign base_sum  = div_quo + {24'd0, cmd_reg.link_latency};
    assign relax_sum = {1'b0, bd_reg} + {1'b0, ram_rdata};
    assign relax_sat = (relax_sum > {1'b0, COST_MAX}) ? COST_MAX : relax_sum[31:0];
    assign link_ix   = {u_reg, idx_reg};
    // unvisited node closer than the best seen in this scan; strict less keeps
    // the lower index on ties
    assign scan_hit  = !visited_reg[idx_reg] && (dist_reg[idx_reg] < bd_reg);
    assign walk_end  = (cur_reg == cmd_reg.src_node) || (n_reg == (NW+1)'(NODES - 1));

    assign busy = (state_reg != S_IDLE);
    assign ram_raddr = link_ix;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {cmd_reg.src_node, cmd_reg.dst_node};
        ram_wdata = cost_reg;
        if (state_reg == S_WR1)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == S_WR2)
        begin
            ram_we    = cmd_reg.both_directions;
            ram_waddr = {cmd_reg.dst_node, cmd_reg.src_node};
        end
    end

    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        unique case (state_reg)
            S_FAIL:
            begin
                res_valid = 1'b1;
                res.last  = 1'b1;
            end
            S_SAME:
            begin
                res_valid      = 1'b1;
                res.path_node  = cmd_reg.src_node;
                res.path_found = 1'b1;
                res.last       = 1'b1;
            end
            S_EMIT:
            begin
                res_valid      = 1'b1;
                res.path_node  = chain_reg[out_reg[NW-1:0]];
                res.path_cost  = dist_reg[cmd_reg.dst_node];
                res.path_found = 1'b1;
                res.last       = (out_reg == '0);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!cmd.func)
                        state_next = S_DIV1;
                    else if (!node_present_reg[cmd.src_node] ||
                             !node_present_reg[cmd.dst_node])
                        state_next = S_FAIL;
                    else if (cmd.src_node == cmd.dst_node)
                        state_next = S_SAME;
                    else
                        state_next = S_SCAN;
                end
            end
            S_DIV1:  if (step_reg == 6'd47) state_next = S_DIV2;
            S_DIV2:  if (step_reg == 6'd47) state_next = S_WR1;
            S_WR1:   state_next = S_WR2;
            S_WR2:   state_next = S_IDLE;
            S_SCAN:
            begin
                if (idx_reg == NW'(NODES - 1))
                begin
                    // nothing left to settle: fail if the destination was never reached, else walk
                    if (!found_u_reg && !scan_hit)
                        state_next = (dist_reg[cmd_reg.dst_node] == COST_UNUSABLE) ?
                                     S_FAIL : S_WALK;
                    else if (scan_hit)
                        state_next = (idx_reg == cmd_reg.dst_node) ? S_WALK : S_RREQ;
                    else
                        state_next = (u_reg == cmd_reg.dst_node) ? S_WALK : S_RREQ;
                end
            end
            S_RREQ:  state_next = S_RELAX;
            S_RELAX: state_next = (idx_reg == NW'(NODES - 1)) ? S_SCAN : S_RREQ;
            S_WALK:  if (walk_end) state_next = S_EMIT;
            S_EMIT:  if (out_reg == '0) state_next = S_IDLE;
            S_FAIL:  state_next = S_IDLE;
            S_SAME:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            node_present_reg <= '0;
            link_present_reg <= '0;
            visited_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg  <= cmd;
                        step_reg <= '0;
                        rem_reg  <= '0;
                        num_reg  <= BW_SCALE;
                        den_reg  <= {28'd0, cmd.link_bandwidth};
                        if (cmd.func)
                        begin
                            for (int i = 0; i < NODES; i++)
                            begin
                                dist_reg[i] <= (NW'(i) == cmd.src_node) ? '0 : COST_UNUSABLE;
                                pred_reg[i] <= '0;
                            end
                            visited_reg <= '0;
                            idx_reg     <= '0;
                            found_u_reg <= 1'b0;
                            bd_reg      <= COST_UNUSABLE;
                        end
                    end
                end
                S_DIV1, S_DIV2:
                begin
                    // one quotient bit per cycle
                    quo_reg <= div_quo;
                    if (step_reg != 6'd47)
                    begin
                        rem_reg  <= div_bit ? rem_shift - {1'b0, den_reg} : rem_shift;
                        num_reg  <= {num_reg[46:0], 1'b0};
                        step_reg <= step_reg + 6'd1;
                    end
                    else
                    begin
                        step_reg <= '0;
                        rem_reg  <= '0;
                        if (state_reg == S_DIV1)
                        begin
                            cost_wide_reg <= base_sum;
                            num_reg <= base_sum << 16;
                            den_reg <= {31'd0, LOSS_FULL - cmd_reg.link_loss};
                        end
                        else
                        begin
                            if (cmd_reg.link_bandwidth == '0 ||
                                cmd_reg.link_loss >= LOSS_FULL)
                                cost_reg <= COST_UNUSABLE;
                            else if (cmd_reg.link_loss == '0)
                                cost_reg <= (cost_wide_reg > {16'd0, COST_MAX}) ?
                                            COST_MAX : cost_wide_reg[31:0];
                            else if (div_quo > {16'd0, COST_MAX})
                                cost_reg <= COST_MAX;
                            else
                                cost_reg <= div_quo[31:0];
                        end
                    end
                end
                S_WR1:
                begin
                    node_present_reg[cmd_reg.src_node] <= 1'b1;
                    node_present_reg[cmd_reg.dst_node] <= 1'b1;
                    link_present_reg[{cmd_reg.src_node, cmd_reg.dst_node}] <= 1'b1;
                end
                S_WR2:
                begin
                    if (cmd_reg.both_directions)
                        link_present_reg[{cmd_reg.dst_node, cmd_reg.src_node}] <= 1'b1;
                end
                S_SCAN:
                begin
                    // one node per cycle
                    if (scan_hit)
                    begin
                        bd_reg      <= dist_reg[idx_reg];
                        u_reg       <= idx_reg;
                        found_u_reg <= 1'b1;
                    end
                    if (idx_reg == NW'(NODES - 1))
                    begin
                        idx_reg <= '0;
                        if (scan_hit)
                            visited_reg[idx_reg] <= 1'b1;
                        else if (found_u_reg)
                            visited_reg[u_reg] <= 1'b1;
                        cur_reg <= cmd_reg.dst_node;
                        n_reg   <= '0;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_RREQ: ;
                S_RELAX:
                begin
                    if (!visited_reg[idx_reg] && link_present_reg[link_ix] &&
                        ram_rdata != COST_UNUSABLE && relax_sat < dist_reg[idx_reg])
                    begin
                        dist_reg[idx_reg] <= relax_sat;
                        pred_reg[idx_reg] <= u_reg;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == NW'(NODES - 1))
                    begin
                        found_u_reg <= 1'b0;
                        bd_reg      <= COST_UNUSABLE;
                    end
                end
                S_WALK:
                begin
                    chain_reg[n_reg[NW-1:0]] <= cur_reg;
                    cur_reg <= pred_reg[cur_reg];
                    n_reg   <= n_reg + 1'b1;
                    if (walk_end)
                        out_reg <= n_reg;
                end
                S_EMIT:  out_reg <= out_reg - 1'b1;
                S_FAIL, S_SAME: ;
                default: ;
            endcase
        end
    end
endmodule

/* hdl/lssp_checker.sv */
// Port-level checker for the shortest-path engine, bound to the top level.
module lssp_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input lssp_pkg::res_t res,
    input logic           res_valid
);
    import lssp_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("accepted item did not raise busy");
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> busy) else $error("result outside a busy window");
    a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.path_found |-> res.last && res.path_cost == '0)
        else $error("bad not-found result");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last |=> !res_valid) else $error("result after last");
endmodule

bind link_state_shortest_path lssp_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .res(res), .res_valid(res_valid)
);

/* tb/link_state_shortest_path_test.sv */
// Self-checking testbench for the link-state shortest-path engine.
module link_state_shortest_path_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lssp_pkg::*;

    localparam logic FN_ADD  = 1'b0;
    localparam logic FN_FIND = 1'b1;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    cmd_t   cmd = '0;
    logic   res_valid;
    res_t   res;

    link_state_shortest_path dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .res_valid(res_valid), .res(res)
    );

    always #5 clk = ~clk;

    // predictor state: graph as seen from outside
    logic        known_node [NODES];
    logic        have_link  [NODES*NODES];
    logic [31:0] arc_cost   [NODES*NODES];

    res_t        path_queue [$];
    int          errors = 0;

    task automatic report(input string what, input res_t got, input res_t want);
        errors++;
        $display("mismatch %s: got node=%0d cost=%h found=%b last=%b %s",
                 what, got.path_node, got.path_cost, got.path_found, got.last,
                 $sformatf("want node=%0d cost=%h found=%b last=%b",
                           want.path_node, want.path_cost, want.path_found,
                           want.last));
    endtask

    task automatic queue_result(input res_t r);
        path_queue = {path_queue, r};
    endtask

    function automatic cmd_t junk_item();
        logic [95:0] noise;
        noise = {$urandom(), $urandom(), $urandom()};
        return noise[$bits(cmd_t)-1:0];
    endfunction

    function automatic logic [31:0] metric(input logic [19:0] bw, input logic [23:0] lat,
                                           input logic [16:0] loss);
        logic [63:0] c;
        if (bw == 0 || loss >= LOSS_FULL)
            return COST_UNUSABLE;
        c = 64'd2560000 / bw + lat;
        if (loss != 0)
            c = (c * 64'd65536) / (64'd65536 - loss);
        if (c > COST_MAX)
            c = COST_MAX;
        return c[31:0];
    endfunction

    // Applies one item to the graph copy and queues the results it causes.
    task automatic predict_item(input cmd_t c);
        logic [31:0] tent_cost [NODES];
        logic [3:0]  pred [NODES];
        logic        done [NODES];
        logic [3:0]  chain [$];
        logic [31:0] bd, ec;
        logic [63:0] nc;
        int          u, s, d, cur;
        res_t        r;
        s = c.src_node;
        d = c.dst_node;
        if (c.func == FN_ADD)
        begin
            ec = metric(c.link_bandwidth, c.link_latency, c.link_loss);
            known_node[s] = 1'b1;
            known_node[d] = 1'b1;
            have_link[s*NODES+d] = 1'b1;
            arc_cost[s*NODES+d] = ec;
            if (c.both_directions)
            begin
                have_link[d*NODES+s] = 1'b1;
                arc_cost[d*NODES+s] = ec;
            end
            return;
        end
        r = '{path_node: 4'd0, path_cost: 32'd0, path_found: 1'b0, last: 1'b1};
        if (!known_node[s] || !known_node[d])
        begin
            queue_result(r);
            return;
        end
        if (s == d)
        begin
            r.path_node = 4'(s);
            r.path_found = 1'b1;
            queue_result(r);
            return;
        end
        for (int i = 0; i < NODES; i++)
        begin
            tent_cost[i] = COST_UNUSABLE;
            pred[i] = '0;
            done[i] = 1'b0;
        end
        tent_cost[s] = '0;
        forever
        begin
            u = NODES;
            bd = COST_UNUSABLE;
            for (int i = 0; i < NODES; i++)
                if (!done[i] && tent_cost[i] < bd)
                begin
                    bd = tent_cost[i];
                    u = i;
                end
            if (u >= NODES) break;
            done[u] = 1'b1;
            if (u == d) break;
            for (int i = 0; i < NODES; i++)
            begin
                if (done[i] || !have_link[u*NODES+i]) continue;
                ec = arc_cost[u*NODES+i];
                if (ec == COST_UNUSABLE) continue;
                nc = {32'd0, bd} + ec;
                if (nc > COST_MAX) nc = COST_MAX;
                if (nc < tent_cost[i])
                begin
                    tent_cost[i] = nc[31:0];
                    pred[i] = 4'(u);
                end
            end
        end
        if (tent_cost[d] == COST_UNUSABLE)
        begin
            queue_result(r);
            return;
        end
        cur = d;
        while (chain.size() < NODES)
        begin
            chain.push_front(4'(cur));
            if (cur == s) break;
            cur = pred[cur];
        end
        foreach (chain[i])
        begin
            r.path_node = chain[i];
            r.path_cost = tent_cost[d];
            r.path_found = 1'b1;
            r.last = (i == chain.size() - 1);
            queue_result(r);
        end
    endtask

    // result checker; the receiver can't stall, so every strobe is taken
    always @(posedge clk)
    begin
        if (rst_n && res_valid)
        begin
            if (path_queue.size() == 0)
                report("unexpected", res, '0);
            else
            begin
                res_t w;
                w = path_queue.pop_front();
                if (res.path_node !== w.path_node) report("path_node", res, w);
                else if (res.path_cost !== w.path_cost) report("path_cost", res, w);
                else if (res.path_found !== w.path_found) report("path_found", res, w);
                else if (res.last !== w.last) report("last", res, w);
            end
        end
    end

    function automatic cmd_t mk(input logic f, input int s, input int d, input logic b,
                                input logic [19:0] bw, input logic [23:0] lat,
                                input logic [16:0] loss);
        cmd_t c;
        c.func = f; c.src_node = 4'(s); c.dst_node = 4'(d); c.both_directions = b;
        c.link_bandwidth = bw; c.link_latency = lat; c.link_loss = loss;
        return c;
    endfunction

    // Directed rows; all predicted, fixed expectations also checked where obvious.
    typedef struct {
        cmd_t c;
        logic fixed;
        res_t r;
    } row_t;
    row_t plan [$];

    task automatic add_row(input cmd_t c, input logic fx, input res_t r);
        row_t w;
        w.c = c; w.fixed = fx; w.r = r;
        plan = {plan, w};
    endtask

    // Sends one item with the burst/gap sender behavior; start stays high
    // between items of a burst.
    int burst_left = 0;
    task automatic send(input cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                cmd <= junk_item();
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    function automatic cmd_t rand_item(input int span);
        cmd_t c;
        c = junk_item();
        c.src_node = 4'($urandom_range(0, span));
        c.dst_node = 4'($urandom_range(0, span));
        case ($urandom_range(0, 9))
            0: c.link_bandwidth = '0;
            1: c.link_loss = LOSS_FULL;
            2, 3, 4, 5:
            begin
                c.link_bandwidth = 20'($urandom_range(1, 10000));
                c.link_latency = 24'($urandom_range(0, 5000));
                c.link_loss = ($urandom_range(0, 3) == 0) ?
                              17'($urandom_range(0, 65535)) : 17'd0;
            end
            default: c.link_loss = 17'($urandom_range(0, 65535));
        endcase
        c.func = ($urandom_range(0, 2) == 0) ? FN_FIND : FN_ADD;
        return c;
    endfunction

    initial
    begin
        res_t none, self0;
        none = '{path_node: 4'd0, path_cost: 32'd0, path_found: 1'b0, last: 1'b1};
        self0 = '{path_node: 4'd3, path_cost: 32'd0, path_found: 1'b1, last: 1'b1};
        foreach (known_node[i]) known_node[i] = 1'b0;
        foreach (have_link[i])
        begin
            have_link[i] = 1'b0;
            arc_cost[i] = '0;
        end

        // after reset nothing is known
        add_row(mk(FN_FIND, 0, 15, 0, 0, 0, 0), 1, none);
        add_row(mk(FN_FIND, 15, 15, 1, '1, '1, '1), 1, none);
        // zero bandwidth: nodes known but link dead
        add_row(mk(FN_ADD, 3, 4, 1, 0, 100, 0), 0, none);
        add_row(mk(FN_FIND, 3, 4, 0, 0, 0, 0), 1, none);
        add_row(mk(FN_FIND, 3, 3, 0, 0, 0, 0), 1, self0);
        // total loss
        add_row(mk(FN_ADD, 4, 5, 0, 1000, 0, LOSS_FULL), 0, none);
        add_row(mk(FN_FIND, 4, 5, 0, 0, 0, 0), 1, none);
        // extreme bandwidth/latency, saturation
        add_row(mk(FN_ADD, 0, 15, 0, 20'hFFFFF, 24'hFFFFFF, 17'd65535), 0, none);
        add_row(mk(FN_ADD, 15, 14, 0, 1, 24'hFFFFFF, 17'd65535), 0, none);
        add_row(mk(FN_FIND, 0, 15, 0, 0, 0, 0), 0, none);
        add_row(mk(FN_FIND, 0, 14, 0, 0, 0, 0), 0, none);
        add_row(mk(FN_FIND, 14, 0, 0, 0, 0, 0), 1, none);
        // tie on equal cost goes to lower index
        add_row(mk(FN_ADD, 1, 2, 1, 10000, 0, 0), 0, none);
        add_row(mk(FN_ADD, 1, 6, 1, 10000, 0, 0), 0, none);
        add_row(mk(FN_ADD, 2, 7, 1, 10000, 0, 0), 0, none);
        add_row(mk(FN_ADD, 6, 7, 1, 10000, 0, 0), 0, none);
        add_row(mk(FN_FIND, 1, 7, 0, 0, 0, 0), 0, none);
        // self link, overwrite, reverse direction
        add_row(mk(FN_ADD, 7, 7, 0, 1, 0, 0), 0, none);
        add_row(mk(FN_ADD, 2, 7, 0, 1, 5, 17'd1), 0, none);
        add_row(mk(FN_FIND, 7, 1, 0, 0, 0, 0), 0, none);
        add_row(mk(FN_FIND, 1, 7, 0, 0, 0, 0), 0, none);
        add_row(mk(FN_FIND, 9, 1, 0, 0, 0, 0), 1, none);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
        begin
            if (plan[k].fixed)
            begin
                predict_item(plan[k].c);
                if (path_queue.size() > 0 && path_queue[$] != plan[k].r)
                    report("table", path_queue[$], plan[k].r);
            end
            else
                predict_item(plan[k].c);
            send(plan[k].c);
        end

        // random: mostly a small dense graph so paths get long, then whole range
        for (int n = 0; n < 330; n++)
        begin
            cmd_t c;
            c = rand_item(n < 230 ? 7 : 15);
            predict_item(c);
            send(c);
        end
        start <= 1'b0;

        while (path_queue.size() != 0) @(posedge clk);
        repeat (1200) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule
